// File: sv/cps_pkg.sv
// Shared types and constants for the process scheduler.
package cps_pkg;

	// Job slots and derived widths
	localparam int MAX_JOBS = 16;
	localparam int IDX_W    = $clog2(MAX_JOBS);
	localparam int CNT_W    = $clog2(MAX_JOBS + 1);

	// Field widths fixed by the interface
	localparam int TICK_W    = 32;
	localparam int QUANTUM_W = 16;
	localparam int JOBCNT_W  = 5;
	localparam int RETIRE_W  = 5;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_W     = 16;
	localparam int ENTRY_W   = 2 * TICK_W;

	localparam int IN_DATA_W  = 72;
	localparam int OUT_DATA_W = 48;

	localparam logic [QUANTUM_W-1:0] QUANTUM_RESET = QUANTUM_W'(500);
	localparam logic [JOBCNT_W-1:0]  JOBCNT_RESET  = JOBCNT_W'(1);
	localparam logic [RETIRE_W-1:0]  RETIRE_MAX    = '1;

	// Configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_POLICY  = 2'd0,
		REG_QUANTUM = 2'd1,
		REG_JOBCNT  = 2'd2
	} cfg_reg_t;

	// Scheduling policies
	typedef enum logic [1:0] {
		POL_FIFO = 2'd0,
		POL_RR   = 2'd1,
		POL_SJF  = 2'd2,
		POL_PSJF = 2'd3
	} policy_t;

	// Input kinds
	typedef enum logic {
		FUNC_LOAD = 1'b0,
		FUNC_TICK = 1'b1
	} func_t;

	// Tick sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_RUN,
		ST_MOD,
		ST_SCAN,
		ST_DECIDE,
		ST_DEC,
		ST_OUT
	} state_t;

	// One scanned slot, offered to the selection unit
	typedef struct packed {
		logic              valid;
		logic              elig;
		logic [IDX_W-1:0]  idx;
		logic [TICK_W-1:0] arrival;
		logic [TICK_W-1:0] remaining;
		logic              by_arrival;
		logic [IDX_W-1:0]  start;
	} sel_in_t;

	// Running picks of the selection unit
	typedef struct packed {
		logic             found_min;
		logic [IDX_W-1:0] min_idx;
		logic             found_any;
		logic [IDX_W-1:0] any_idx;
		logic             found_hi;
		logic [IDX_W-1:0] hi_idx;
	} sel_res_t;

endpackage

// File: sv/cps_job_mem.sv
// Job table: arrival tick and remaining time per slot, one write and one read port.
module cps_job_mem (
	input  logic                        clk,
	input  logic                        we,
	input  logic [cps_pkg::IDX_W-1:0]   waddr,
	input  logic [cps_pkg::ENTRY_W-1:0] wdata,
	input  logic [cps_pkg::IDX_W-1:0]   raddr,
	output logic [cps_pkg::ENTRY_W-1:0] rdata
);
	import cps_pkg::*;

	logic [ENTRY_W-1:0] mem [MAX_JOBS];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

// File: sv/cps_select.sv
// Selection unit: one key compare per cycle, tracks min-key, first and first-from-start picks.
module cps_select (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              clear,
	input  cps_pkg::sel_in_t  sin,
	output cps_pkg::sel_res_t res
);
	import cps_pkg::*;

	sel_res_t          res_q;
	logic [TICK_W-1:0] best_key_q;
	logic [TICK_W-1:0] key;
	logic              take_min;
	logic              take_any;
	logic              take_hi;

	// Shared compare
	always_comb begin
		key      = sin.by_arrival ? sin.arrival : sin.remaining;
		take_min = sin.valid && sin.elig && (!res_q.found_min || key < best_key_q);
		take_any = sin.valid && sin.elig && !res_q.found_any;
		take_hi  = sin.valid && sin.elig && !res_q.found_hi && (sin.idx >= sin.start);
	end

	// Pick registers; slots arrive in ascending order so ties keep the lower slot
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_q      <= '0;
			best_key_q <= '0;
		end else if (clear) begin
			res_q      <= '0;
			best_key_q <= '0;
		end else begin
			if (take_min) begin
				res_q.found_min <= 1'b1;
				res_q.min_idx   <= sin.idx;
				best_key_q      <= key;
			end
			if (take_any) begin
				res_q.found_any <= 1'b1;
				res_q.any_idx   <= sin.idx;
			end
			if (take_hi) begin
				res_q.found_hi <= 1'b1;
				res_q.hi_idx   <= sin.idx;
			end
		end
	end

	assign res = res_q;

endmodule

// File: sv/cpu_process_scheduler.sv
// Single-core job scheduler top level: FIFO, round robin, SJF and preemptive SJF.
//
// Input stream: tuser is func (0 load a job slot, 1 advance one tick); tdata carries
// slot, arrival_tick and service_ticks. A load transfer gives no result. A tick
// transfer gives exactly one result on the output stream: running job, switch flag,
// retired job, all-done flag and the tick number handled.
// For a tick, n is the number of slots in use (job_count clamped to 1..16): the job
// table has one read port and every slot in use is read once through it and fed to
// the shared key compare. In round robin the successor start slot is first reduced
// modulo n by repeated subtraction.
// The input side is ready only while no tick is in work. The result sits in an output
// register; a stalled receiver lets the next tick be taken and worked, which then waits
// in its last step until the register is free.
// Configuration (policy, quantum, job count) is written through cfg_we/cfg_addr/cfg_wdata;
// the user must write it only while the block is idle; the block does not enforce it.
// Reset clears all arrived flags, the running job, the tick count, the slice and retired
// counters and loads the register defaults; the job table holds nothing until loaded.
module cpu_process_scheduler (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_axis_tvalid,
	output logic                           s_axis_tready,
	// slot[3:0], arrival_tick[35:4], service_ticks[67:36], zero fill
	input  logic [cps_pkg::IN_DATA_W-1:0]  s_axis_tdata,
	// func[0]
	input  logic                           s_axis_tuser,
	output logic                           m_axis_tvalid,
	input  logic                           m_axis_tready,
	// running_valid[0], running_slot[4:1], switched[5], finished_valid[6],
	// finished_slot[10:7], all_done[11], current_tick[43:12], zero fill
	output logic [cps_pkg::OUT_DATA_W-1:0] m_axis_tdata,
	input  logic                           cfg_we,
	input  logic [cps_pkg::CFG_IDX_W-1:0]  cfg_addr,
	input  logic [cps_pkg::CFG_W-1:0]      cfg_wdata
);
	import cps_pkg::*;

	// Configuration registers
	policy_t              policy_q;
	logic [QUANTUM_W-1:0] quantum_q;
	logic [JOBCNT_W-1:0]  job_count_q;

	// Scheduler state
	state_t               state_q, state_d;
	logic [MAX_JOBS-1:0]  arrived_q;
	logic                 run_q;
	logic [IDX_W-1:0]     run_idx_q;
	logic [TICK_W-1:0]    tick_q;
	logic [QUANTUM_W-1:0] slice_q;
	logic [RETIRE_W-1:0]  retired_q;
	logic                 fin_q;
	logic [IDX_W-1:0]     fin_slot_q;
	logic                 sw_q;
	logic [CNT_W-1:0]     start_q;
	logic [CNT_W-1:0]     iss_q;
	logic                 pend_vld_s1;
	logic [IDX_W-1:0]     pend_idx_s1;

	// Output register
	logic                  out_vld_q;
	logic [OUT_DATA_W-1:0] out_data_q;

	// Table port and selection unit
	logic                 mem_we;
	logic [IDX_W-1:0]     mem_waddr;
	logic [ENTRY_W-1:0]   mem_wdata;
	logic [IDX_W-1:0]     mem_raddr;
	logic [ENTRY_W-1:0]   mem_rdata;
	logic [TICK_W-1:0]    rd_rem;
	logic [TICK_W-1:0]    rd_arr;
	sel_in_t              sel_in;
	sel_res_t             sel_res;
	logic                 sel_clear;

	// Derived values
	logic [CNT_W-1:0]     n_use;
	logic                 in_xfer;
	logic                 out_free;
	logic                 scan_match;
	logic                 scan_elig;
	logic                 have;
	logic [IDX_W-1:0]     nxt;
	logic                 sw_d;
	logic [IDX_W-1:0]     run_idx_new;
	logic [QUANTUM_W:0]   q_eff;
	logic [QUANTUM_W:0]   slice_inc;
	logic                 all_done;

	assign rd_rem   = mem_rdata[TICK_W-1:0];
	assign rd_arr   = mem_rdata[ENTRY_W-1:TICK_W];
	assign in_xfer  = s_axis_tvalid && s_axis_tready;
	assign out_free = !out_vld_q || m_axis_tready;

	// Slots in use, clamped to 1..MAX_JOBS
	always_comb begin
		if (job_count_q == '0) begin
			n_use = CNT_W'(1);
		end else if (CNT_W'(job_count_q) > CNT_W'(MAX_JOBS)) begin
			n_use = CNT_W'(MAX_JOBS);
		end else begin
			n_use = CNT_W'(job_count_q);
		end
	end

	// Arrival check of the slot read back during the scan
	assign scan_match = pend_vld_s1 && (rd_arr == tick_q);
	assign scan_elig  = (arrived_q[pend_idx_s1] || scan_match) && (rd_rem != '0);

	always_comb begin
		sel_in.valid      = (state_q == ST_SCAN) && pend_vld_s1;
		sel_in.elig       = scan_elig;
		sel_in.idx        = pend_idx_s1;
		sel_in.arrival    = rd_arr;
		sel_in.remaining  = rd_rem;
		sel_in.by_arrival = (policy_q == POL_FIFO);
		sel_in.start      = start_q[IDX_W-1:0];
	end

	// Policy decision from the scan picks
	always_comb begin
		have = 1'b0;
		nxt  = run_idx_q;
		case (policy_q)
			POL_FIFO, POL_SJF: begin
				if (run_q) begin
					have = 1'b1;
					nxt  = run_idx_q;
				end else begin
					have = sel_res.found_min;
					nxt  = sel_res.min_idx;
				end
			end
			POL_PSJF: begin
				have = sel_res.found_min;
				nxt  = sel_res.min_idx;
			end
			POL_RR: begin
				if (!run_q) begin
					have = sel_res.found_any;
					nxt  = sel_res.any_idx;
				end else if (slice_q == '0) begin
					have = sel_res.found_hi || sel_res.found_any;
					nxt  = sel_res.found_hi ? sel_res.hi_idx : sel_res.any_idx;
				end
			end
			default: begin
				have = 1'b0;
				nxt  = run_idx_q;
			end
		endcase
		sw_d        = have && (!run_q || nxt != run_idx_q);
		run_idx_new = sw_d ? nxt : run_idx_q;
	end

	// Slice counter wrap and done flag
	assign q_eff     = (quantum_q == '0) ? (QUANTUM_W+1)'(1) : {1'b0, quantum_q};
	assign slice_inc = {1'b0, slice_q} + (QUANTUM_W+1)'(1);
	assign all_done  = (CNT_W'(retired_q) >= n_use);

	// Sequencer: next state and table port
	always_comb begin
		state_d   = state_q;
		mem_we    = 1'b0;
		mem_waddr = run_idx_q;
		mem_wdata = mem_rdata;
		mem_raddr = run_idx_q;
		sel_clear = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (in_xfer) begin
					if (func_t'(s_axis_tuser) == FUNC_LOAD) begin
						mem_we    = 1'b1;
						mem_waddr = s_axis_tdata[IDX_W-1:0];
						mem_wdata = {s_axis_tdata[IDX_W+TICK_W-1:IDX_W],
							s_axis_tdata[IDX_W+2*TICK_W-1:IDX_W+TICK_W]};
					end else begin
						state_d = ST_RUN;
					end
				end
			end
			ST_RUN: begin
				sel_clear = 1'b1;
				state_d   = (policy_q == POL_RR) ? ST_MOD : ST_SCAN;
			end
			ST_MOD: begin
				if (start_q < n_use) begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				mem_raddr = iss_q[IDX_W-1:0];
				if (iss_q >= n_use && !pend_vld_s1) begin
					state_d = ST_DECIDE;
				end
			end
			ST_DECIDE: begin
				mem_raddr = run_idx_new;
				state_d   = ST_DEC;
			end
			ST_DEC: begin
				if (run_q && rd_rem != '0) begin
					mem_we    = 1'b1;
					mem_waddr = run_idx_q;
					mem_wdata = {rd_arr, rd_rem - TICK_W'(1)};
				end
				state_d = ST_OUT;
			end
			ST_OUT: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign s_axis_tready = (state_q == ST_IDLE);

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			policy_q    <= POL_FIFO;
			quantum_q   <= QUANTUM_RESET;
			job_count_q <= JOBCNT_RESET;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_addr))
				REG_POLICY:  policy_q    <= policy_t'(cfg_wdata[1:0]);
				REG_QUANTUM: quantum_q   <= cfg_wdata[QUANTUM_W-1:0];
				REG_JOBCNT:  job_count_q <= cfg_wdata[JOBCNT_W-1:0];
				default: ;
			endcase
		end
	end

	// Sequencer and scheduler state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			arrived_q   <= '0;
			run_q       <= 1'b0;
			run_idx_q   <= '0;
			tick_q      <= '0;
			slice_q     <= '0;
			retired_q   <= '0;
			fin_q       <= 1'b0;
			fin_slot_q  <= '0;
			sw_q        <= 1'b0;
			start_q     <= '0;
			iss_q       <= '0;
			pend_vld_s1 <= 1'b0;
			pend_idx_s1 <= '0;
		end else begin
			state_q <= state_d;
			case (state_q)
				ST_IDLE: begin
					if (in_xfer && func_t'(s_axis_tuser) == FUNC_LOAD) begin
						arrived_q[s_axis_tdata[IDX_W-1:0]] <= 1'b0;
					end
				end
				// Retire a finished running job
				ST_RUN: begin
					if (run_q && rd_rem == '0) begin
						fin_q      <= 1'b1;
						fin_slot_q <= run_idx_q;
						run_q      <= 1'b0;
						if (retired_q != RETIRE_MAX) begin
							retired_q <= retired_q + RETIRE_W'(1);
						end
					end else begin
						fin_q      <= 1'b0;
						fin_slot_q <= '0;
					end
					start_q     <= CNT_W'(run_idx_q) + CNT_W'(1);
					iss_q       <= '0;
					pend_vld_s1 <= 1'b0;
				end
				// Round robin start slot modulo slots in use
				ST_MOD: begin
					if (start_q >= n_use) begin
						start_q <= start_q - n_use;
					end
				end
				// One table read issued and one slot checked per cycle
				ST_SCAN: begin
					if (iss_q < n_use) begin
						iss_q       <= iss_q + CNT_W'(1);
						pend_vld_s1 <= 1'b1;
						pend_idx_s1 <= iss_q[IDX_W-1:0];
					end else begin
						pend_vld_s1 <= 1'b0;
					end
					if (scan_match) begin
						arrived_q[pend_idx_s1] <= 1'b1;
					end
				end
				ST_DECIDE: begin
					sw_q <= sw_d;
					if (sw_d) begin
						run_q     <= 1'b1;
						run_idx_q <= nxt;
						slice_q   <= '0;
					end
				end
				ST_OUT: begin
					if (out_free) begin
						slice_q <= (slice_inc >= q_eff) ? '0 : slice_inc[QUANTUM_W-1:0];
						tick_q  <= tick_q + TICK_W'(1);
					end
				end
				default: ;
			endcase
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (state_q == ST_OUT && out_free) begin
			out_vld_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_OUT && out_free) begin
			out_data_q <= {4'b0, tick_q, all_done, fin_slot_q, fin_q, sw_q,
				(run_q ? run_idx_q : IDX_W'(0)), run_q};
		end
	end

	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tdata  = out_data_q;

	cps_job_mem u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	cps_select u_sel (
		.clk    (clk),
		.arst_n (arst_n),
		.clear  (sel_clear),
		.sin    (sel_in),
		.res    (sel_res)
	);

	// Retired count only grows until reset
	a_retired_mono: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> retired_q >= $past(retired_q))
		else $error("retired count decreased");

	// A switch always leaves a job running
	a_switch_runs: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DECIDE && sw_d) |=> run_q)
		else $error("switch without a running job");

	// The table is never written while slots are being scanned
	a_scan_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN || state_q == ST_MOD) |-> !mem_we)
		else $error("table write during scan");

	// A round robin scan starts from a slot inside the range in use
	a_start_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN && policy_q == POL_RR) |-> start_q < n_use)
		else $error("round robin start slot out of range");

endmodule
